FILE: hdl/kwb_pkg.sv
package kwb_pkg;

  // Default store depths
  localparam int unsigned EDIT_DEPTH_DEF = 32;
  localparam int unsigned SEND_DEPTH_DEF = 128;

  // Field widths fixed by the stream layout
  localparam int unsigned REQ_W      = 4;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned INDEX_W    = 7;
  localparam int unsigned EDIT_LEN_W = 6;
  localparam int unsigned SEND_LEN_W = 8;

  // Word separator placed after every committed line
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND     = 4'd0,
    REQ_BACKSPACE  = 4'd1,
    REQ_COMMIT     = 4'd2,
    REQ_REVERT     = 4'd3,
    REQ_POP        = 4'd4,
    REQ_CLEAR_EDIT = 4'd5,
    REQ_CLEAR_SEND = 4'd6,
    REQ_READ_EDIT  = 4'd7,
    REQ_READ_SEND  = 4'd8
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMT_COPY,
    ST_RV_SETUP,
    ST_RV_RD,
    ST_RV_CHK,
    ST_RV_LEN,
    ST_RV_COPY,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

endpackage

FILE: hdl/keyer_word_buffer.sv
// Word buffer for a Morse keyer: an edit line and a circular send queue, each in a
// single-port-write, registered-read memory, driven by one small sequencer. One request
// is taken at a time and s_axis_tready is low while it is worked on. Append, backspace,
// clears and rejected requests go straight to the result state; pop and indexed reads
// pass through a wait state first, for the registered memory read. A commit moves one
// character per cycle from edit line to queue, then the space. A revert scans the
// queue backwards for the previous space, each character examined in an address
// state and then a compare state, then copies the word back at one character per
// cycle. The result register frees the input side: a new request is taken while the
// previous result still waits on the master side.
module keyer_word_buffer #(
  parameter int unsigned EDIT_DEPTH = kwb_pkg::EDIT_DEPTH_DEF,
  parameter int unsigned SEND_DEPTH = kwb_pkg::SEND_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] char_in, [14:8] read_index, [15] zero
  input  logic [3:0]  s_axis_tuser,  // [3:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] data_char, [13:8] edit_length,
                                     // [21:14] send_length, [23:22] zero
  output logic        m_axis_tuser   // [0] rejected
);

  localparam int unsigned EP = $clog2(EDIT_DEPTH);
  localparam int unsigned EC = $clog2(EDIT_DEPTH + 1);
  localparam int unsigned SP = $clog2(SEND_DEPTH);
  localparam int unsigned SC = $clog2(SEND_DEPTH + 1);
  localparam int unsigned RW = ((SP > kwb_pkg::INDEX_W) ? SP : kwb_pkg::INDEX_W) + 1;
  localparam int unsigned TW = SC + 1;
  localparam int unsigned CW = kwb_pkg::CHAR_W;

  // Stores
  logic [CW-1:0] edit_mem [EDIT_DEPTH];
  logic [CW-1:0] send_mem [SEND_DEPTH];

  logic          edit_we;
  logic [EP-1:0] edit_waddr, edit_raddr;
  logic [CW-1:0] edit_wdata, edit_rd_q;
  logic          send_we;
  logic [SP-1:0] send_waddr, send_raddr;
  logic [CW-1:0] send_wdata, send_rd_q;

  // Sequencer and counters
  kwb_pkg::state_e state_q, state_d;
  kwb_pkg::req_e   req_q, req_d;
  logic [EC-1:0] edit_count_q, edit_count_d;
  logic [SC-1:0] send_count_q, send_count_d;
  logic [SP-1:0] head_q, head_d;
  logic [SP-1:0] ptr_q, ptr_d;
  logic [SC-1:0] k_q, k_d;
  logic [EC-1:0] j_q, j_d;
  logic [EC-1:0] n_q, n_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] res_data_q, res_data_d;
  logic          res_rej_q, res_rej_d;

  // Result register
  logic          m_valid_q, m_valid_d;
  logic [23:0]   m_data_q, m_data_d;
  logic          m_rej_q, m_rej_d;

  // Input fields
  kwb_pkg::req_e              in_req;
  logic [CW-1:0]              in_char;
  logic [kwb_pkg::INDEX_W-1:0] in_idx;

  logic [RW-1:0] rd_sum;
  logic [SP-1:0] rd_pos;
  logic [TW-1:0] tl_sum;
  logic [SP-1:0] tail_pos;
  logic [SC-1:0] rv_diff;

  assign in_req  = kwb_pkg::req_e'(s_axis_tuser);
  assign in_char = s_axis_tdata[7:0];
  assign in_idx  = s_axis_tdata[14:8];

  // Queue position of a read index, head plus index folded once
  assign rd_sum = RW'(head_q) + RW'(in_idx);
  assign rd_pos = (rd_sum >= RW'(SEND_DEPTH)) ? SP'(rd_sum - RW'(SEND_DEPTH)) : SP'(rd_sum);

  // Queue tail position
  assign tl_sum   = TW'(head_q) + TW'(send_count_q);
  assign tail_pos = (tl_sum >= TW'(SEND_DEPTH)) ? SP'(tl_sum - TW'(SEND_DEPTH)) : SP'(tl_sum);

  // Length of the reverted word before the edit limit
  assign rv_diff = send_count_q - SC'(1) - k_q;

  assign s_axis_tready = (state_q == kwb_pkg::ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_rej_q;

  // Next state, memory ports and result
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    edit_count_d = edit_count_q;
    send_count_d = send_count_q;
    head_d       = head_q;
    ptr_d        = ptr_q;
    k_d          = k_q;
    j_d          = j_q;
    n_d          = n_q;
    pend_d       = 1'b0;
    res_data_d   = res_data_q;
    res_rej_d    = res_rej_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_rej_d      = m_rej_q;

    edit_we    = 1'b0;
    edit_waddr = j_q[EP-1:0];
    edit_wdata = send_rd_q;
    edit_raddr = j_q[EP-1:0];
    send_we    = 1'b0;
    send_waddr = ptr_q;
    send_wdata = edit_rd_q;
    send_raddr = ptr_q;

    unique case (state_q)
      kwb_pkg::ST_IDLE: begin
        edit_raddr = EP'(in_idx);
        send_raddr = (in_req == kwb_pkg::REQ_POP) ? head_q : rd_pos;
        if (s_axis_tvalid) begin
          req_d      = in_req;
          res_data_d = '0;
          res_rej_d  = 1'b1;
          state_d    = kwb_pkg::ST_DONE;
          case (in_req)
            kwb_pkg::REQ_APPEND: begin
              if (in_char != '0 && int'(edit_count_q) < EDIT_DEPTH) begin
                edit_we      = 1'b1;
                edit_waddr   = edit_count_q[EP-1:0];
                edit_wdata   = in_char;
                edit_count_d = edit_count_q + EC'(1);
                res_rej_d    = 1'b0;
              end
            end
            kwb_pkg::REQ_BACKSPACE: begin
              if (edit_count_q != '0) begin
                edit_count_d = edit_count_q - EC'(1);
                res_rej_d    = 1'b0;
              end
            end
            kwb_pkg::REQ_COMMIT: begin
              if (edit_count_q != '0 &&
                  int'(send_count_q) + int'(edit_count_q) + 1 <= int'(SEND_DEPTH)) begin
                ptr_d   = tail_pos;
                j_d     = '0;
                state_d = kwb_pkg::ST_CMT_COPY;
              end
            end
            kwb_pkg::REQ_REVERT: begin
              if (edit_count_q == '0 && send_count_q != '0) begin
                if (send_count_q == SC'(1)) begin
                  // Lone trailing character: drop it, nothing to copy back
                  send_count_d = '0;
                  res_rej_d    = 1'b0;
                end else begin
                  ptr_d   = tail_pos;
                  k_d     = send_count_q - SC'(1);
                  state_d = kwb_pkg::ST_RV_SETUP;
                end
              end
            end
            kwb_pkg::REQ_POP: begin
              if (send_count_q != '0) begin
                head_d       = (head_q == SP'(SEND_DEPTH - 1)) ? '0 : head_q + SP'(1);
                send_count_d = send_count_q - SC'(1);
                res_rej_d    = 1'b0;
                state_d      = kwb_pkg::ST_RD_WAIT;
              end
            end
            kwb_pkg::REQ_CLEAR_EDIT: begin
              edit_count_d = '0;
              res_rej_d    = 1'b0;
            end
            kwb_pkg::REQ_CLEAR_SEND: begin
              send_count_d = '0;
              head_d       = '0;
              res_rej_d    = 1'b0;
            end
            kwb_pkg::REQ_READ_EDIT: begin
              if (int'(in_idx) < int'(edit_count_q)) begin
                res_rej_d = 1'b0;
                state_d   = kwb_pkg::ST_RD_WAIT;
              end
            end
            kwb_pkg::REQ_READ_SEND: begin
              if (int'(in_idx) < int'(send_count_q)) begin
                res_rej_d = 1'b0;
                state_d   = kwb_pkg::ST_RD_WAIT;
              end
            end
            default: begin
              res_rej_d = 1'b1;
            end
          endcase
        end
      end

      // Move the edit line to the queue tail, each character written in the cycle after its read
      kwb_pkg::ST_CMT_COPY: begin
        if (j_q != edit_count_q) begin
          edit_raddr = j_q[EP-1:0];
          j_d        = j_q + EC'(1);
          pend_d     = 1'b1;
        end
        if (pend_q) begin
          send_we    = 1'b1;
          send_waddr = ptr_q;
          send_wdata = edit_rd_q;
          ptr_d      = (ptr_q == SP'(SEND_DEPTH - 1)) ? '0 : ptr_q + SP'(1);
        end
        if (j_q == edit_count_q && !pend_q) begin
          send_we      = 1'b1;
          send_waddr   = ptr_q;
          send_wdata   = kwb_pkg::SPACE_CHAR;
          send_count_d = send_count_q + SC'(edit_count_q) + SC'(1);
          edit_count_d = '0;
          res_rej_d    = 1'b0;
          state_d      = kwb_pkg::ST_DONE;
        end
      end

      // Step back from the tail to the second-to-last character
      kwb_pkg::ST_RV_SETUP: begin
        ptr_d   = (ptr_q >= SP'(2)) ? ptr_q - SP'(2) : ptr_q + SP'(SEND_DEPTH - 2);
        state_d = kwb_pkg::ST_RV_RD;
      end

      kwb_pkg::ST_RV_RD: begin
        send_raddr = ptr_q;
        state_d    = kwb_pkg::ST_RV_CHK;
      end

      // Stop at a space, else move one back; no space means the word starts at the head
      kwb_pkg::ST_RV_CHK: begin
        if (send_rd_q == kwb_pkg::SPACE_CHAR) begin
          ptr_d   = (ptr_q == SP'(SEND_DEPTH - 1)) ? '0 : ptr_q + SP'(1);
          state_d = kwb_pkg::ST_RV_LEN;
        end else if (k_q == SC'(1)) begin
          k_d     = '0;
          ptr_d   = head_q;
          state_d = kwb_pkg::ST_RV_LEN;
        end else begin
          k_d     = k_q - SC'(1);
          ptr_d   = (ptr_q == '0) ? SP'(SEND_DEPTH - 1) : ptr_q - SP'(1);
          state_d = kwb_pkg::ST_RV_RD;
        end
      end

      // Clip the word to the edit line depth
      kwb_pkg::ST_RV_LEN: begin
        if (int'(rv_diff) > int'(EDIT_DEPTH)) begin
          n_d = EC'(EDIT_DEPTH);
        end else begin
          n_d = EC'(rv_diff);
        end
        j_d     = '0;
        state_d = kwb_pkg::ST_RV_COPY;
      end

      // Copy the word back into the edit line, each character written in the cycle after its read
      kwb_pkg::ST_RV_COPY: begin
        if (n_q != '0) begin
          send_raddr = ptr_q;
          ptr_d      = (ptr_q == SP'(SEND_DEPTH - 1)) ? '0 : ptr_q + SP'(1);
          n_d        = n_q - EC'(1);
          pend_d     = 1'b1;
        end
        if (pend_q) begin
          edit_we    = 1'b1;
          edit_waddr = j_q[EP-1:0];
          edit_wdata = send_rd_q;
          j_d        = j_q + EC'(1);
        end
        if (n_q == '0 && !pend_q) begin
          edit_count_d = j_q;
          send_count_d = k_q;
          res_rej_d    = 1'b0;
          state_d      = kwb_pkg::ST_DONE;
        end
      end

      kwb_pkg::ST_RD_WAIT: begin
        res_data_d = (req_q == kwb_pkg::REQ_READ_EDIT) ? edit_rd_q : send_rd_q;
        state_d    = kwb_pkg::ST_DONE;
      end

      // Hand the result to the output register once it is free
      kwb_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00,
                       kwb_pkg::SEND_LEN_W'(send_count_q),
                       kwb_pkg::EDIT_LEN_W'(edit_count_q),
                       res_data_q};
          m_rej_d   = res_rej_q;
          state_d   = kwb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = kwb_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kwb_pkg::ST_IDLE;
      edit_count_q <= '0;
      send_count_q <= '0;
      head_q       <= '0;
      pend_q       <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      edit_count_q <= edit_count_d;
      send_count_q <= send_count_d;
      head_q       <= head_d;
      pend_q       <= pend_d;
      m_valid_q    <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    ptr_q      <= ptr_d;
    k_q        <= k_d;
    j_q        <= j_d;
    n_q        <= n_d;
    res_data_q <= res_data_d;
    res_rej_q  <= res_rej_d;
    m_data_q   <= m_data_d;
    m_rej_q    <= m_rej_d;
  end

  // Edit line memory
  always_ff @(posedge clk_i) begin
    if (edit_we) begin
      edit_mem[edit_waddr] <= edit_wdata;
    end
    edit_rd_q <= edit_mem[edit_raddr];
  end

  // Send queue memory
  always_ff @(posedge clk_i) begin
    if (send_we) begin
      send_mem[send_waddr] <= send_wdata;
    end
    send_rd_q <= send_mem[send_raddr];
  end

endmodule
